>>> rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_BYTES      = 65536;
    localparam int MAX_FREE_ENTRIES = 64;
    localparam int HDR_BYTES        = 16;
    localparam int CNT_W            = $clog2(MAX_FREE_ENTRIES + 1);
    localparam int HDR_DEPTH        = ARENA_BYTES / 8;
    localparam int HDR_AW           = $clog2(HDR_DEPTH);
    localparam int OFF_W            = 16;
    localparam int SIZE_W           = 17;
    localparam int REQ_W            = 18;
    localparam int SUM_W            = 19;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NULL = 2'd1,
        STAT_OOM  = 2'd2,
        STAT_FULL = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef struct packed {
        logic        req_type;
        logic [16:0] alloc_size;
        logic [15:0] free_address;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] address;
    } t_out_item;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_START,
        CELL_STEP,
        CELL_PUSH,
        CELL_REMOVE,
        CELL_SPLIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [REQ_W-1:0] req;
        t_entry           upd;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SEARCH,
        ST_APPLY,
        ST_RESP
    } t_state;

endpackage

>>> rtl/core/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ffba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cell
// One free-table entry: holds offset and size, passes the search token on.
// ----------------------------------------------------------------------------
module ffba_cell
    import ffba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_head,
    input  logic      i_tok,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_tok,
    output logic      o_found,
    output t_entry    o_sel
);

    t_entry r_entry;
    logic   r_tok;
    logic   r_past;
    logic   w_hit;

    assign w_hit   = ({1'b0, r_entry.size} >= i_ctl.req);
    assign o_entry = r_entry;
    assign o_tok   = r_tok;
    assign o_found = r_tok & w_hit;
    assign o_sel   = r_tok ? r_entry : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_past <= 1'b0;
        end else begin
            case (i_ctl.op)
                CELL_START: begin
                    r_tok  <= i_head;
                    r_past <= 1'b0;
                end
                CELL_STEP: begin
                    // token moves one cell down; mark cells it has left
                    r_tok  <= i_tok;
                    r_past <= r_past | r_tok;
                end
                default: begin
                    r_tok  <= r_tok;
                    r_past <= r_past;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_PUSH: r_entry <= i_prev;
            CELL_REMOVE: begin
                if (!r_past) begin
                    r_entry <= i_next;
                end
            end
            CELL_SPLIT: begin
                if (r_tok) begin
                    r_entry <= i_ctl.upd;
                end
            end
            default: r_entry <= r_entry;
        endcase
    end

endmodule

>>> rtl/core/first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over a 64 KiB arena with a LIFO free table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries allocate and free
//   requests; output channel (o_out_valid / i_out_stall / o_out) returns one
//   status/address result per request, in order.
//   One request is worked on at a time. The free table is a row of 64 cells;
//   an allocate passes a search token down the row, one cell per cycle.
//   Path from transfer to result register:
//     null, zero-size or table-full request: straight to the result
//     free: header size RAM read, then push into the row
//     allocate: search over k entries (0..64), then apply to the entry or bump
//   The next request is taken once the result is in the output register,
//   even while the receiver still stalls it. A stalled result holds; a
//   second result waits in the sequencer until the first is taken.
//   Reset empties the free table and the bump pointer at once; header RAM
//   contents stay undefined until written by an allocation.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [SIZE_W-1:0]   r_bump, n_bump;
    logic [REQ_W-1:0]    r_req, n_req;
    logic [OFF_W-1:0]    r_hdr, n_hdr;
    t_out_item           r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic [OFF_W-1:0]    w_hdr;
    logic [REQ_W-1:0]    w_round;
    t_entry              w_sel;
    logic                w_found;
    logic [SUM_W-1:0]    w_split_lim;
    logic                w_split;
    logic [SUM_W-1:0]    w_bump_sum;
    logic                w_oom;

    logic                w_we;
    logic [HDR_AW-1:0]   w_waddr;
    logic [SIZE_W-1:0]   w_wdata;
    logic [SIZE_W-1:0]   w_rdata;

    t_entry              w_entry [MAX_FREE_ENTRIES];
    t_entry              w_csel  [MAX_FREE_ENTRIES];
    logic [MAX_FREE_ENTRIES-1:0] w_tok;
    logic [MAX_FREE_ENTRIES-1:0] w_cfound;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_hdr   = i_in.free_address - OFF_W'(HDR_BYTES);
    assign w_round = ({1'b0, i_in.alloc_size} + REQ_W'(7)) & ~REQ_W'(7);

    // Row of table cells
    for (genvar g = 0; g < MAX_FREE_ENTRIES; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_tin;
        if (g == 0) begin : g_first
            assign w_prev = t_entry'{off: r_hdr, size: w_rdata};
            assign w_tin  = 1'b0;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
            assign w_tin  = w_tok[g-1];
        end
        if (g == MAX_FREE_ENTRIES - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_head  ((g == 0) ? 1'b1 : 1'b0),
            .i_tok   (w_tin),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_tok   (w_tok[g]),
            .o_found (w_cfound[g]),
            .o_sel   (w_csel[g])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < MAX_FREE_ENTRIES; i++) begin
            w_sel = t_entry'(w_sel | w_csel[i]);
        end
    end

    assign w_found     = |w_cfound;
    assign w_split_lim = {1'b0, r_req} + SUM_W'(HDR_BYTES);
    assign w_split     = ({2'b0, w_sel.size} > w_split_lim);
    assign w_bump_sum  = {2'b0, r_bump} + {1'b0, r_req} + SUM_W'(HDR_BYTES);
    assign w_oom       = (w_bump_sum > SUM_W'(ARENA_BYTES));

    ffba_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_hdr[3 +: HDR_AW]),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type == REQ_FREE) begin
                        if (i_in.free_address == '0
                            || r_count >= CNT_W'(MAX_FREE_ENTRIES)) begin
                            n_state = ST_RESP;
                        end else begin
                            n_state = ST_PUSH;
                        end
                    end else if (i_in.alloc_size == '0) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_PUSH:   n_state = ST_RESP;
            ST_SEARCH: begin
                if (r_idx == r_count) begin
                    n_state = ST_RESP;
                end else if (w_found) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY:  n_state = ST_RESP;
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_bump      = r_bump;
        n_req       = r_req;
        n_hdr       = r_hdr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_ctl.op    = CELL_HOLD;
        w_ctl.req   = r_req;
        w_ctl.upd.off  = w_sel.off + OFF_W'(HDR_BYTES) + r_req[OFF_W-1:0];
        w_ctl.upd.size = w_sel.size - r_req[SIZE_W-1:0] - SIZE_W'(HDR_BYTES);
        w_we        = 1'b0;
        w_waddr     = w_sel.off[3 +: HDR_AW];
        w_wdata     = r_req[SIZE_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_hdr       = w_hdr;
                    n_req       = w_round;
                    n_idx       = '0;
                    n_res       = t_out_item'{status: STAT_NULL, address: '0};
                    if (i_in.req_type == REQ_FREE) begin
                        if (i_in.free_address != '0
                            && r_count >= CNT_W'(MAX_FREE_ENTRIES)) begin
                            n_res.status = STAT_FULL;
                        end
                    end else if (i_in.alloc_size != '0) begin
                        w_ctl.op = CELL_START;
                    end
                end
            end
            ST_PUSH: begin
                w_ctl.op = CELL_PUSH;
                n_count  = r_count + CNT_W'(1);
                n_res    = t_out_item'{status: STAT_OK, address: '0};
            end
            ST_SEARCH: begin
                if (r_idx == r_count) begin
                    // no entry fits: bump from the arena
                    if (w_oom) begin
                        n_res = t_out_item'{status: STAT_OOM, address: '0};
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_bump[3 +: HDR_AW];
                        n_bump  = w_bump_sum[SIZE_W-1:0];
                        n_res   = t_out_item'{status: STAT_OK,
                            address: r_bump[OFF_W-1:0] + OFF_W'(HDR_BYTES)};
                    end
                end else if (!w_found) begin
                    w_ctl.op = CELL_STEP;
                    n_idx    = r_idx + CNT_W'(1);
                end
            end
            ST_APPLY: begin
                w_we  = 1'b1;
                n_res = t_out_item'{status: STAT_OK,
                    address: w_sel.off + OFF_W'(HDR_BYTES)};
                if (w_split) begin
                    w_ctl.op = CELL_SPLIT;
                end else begin
                    w_ctl.op = CELL_REMOVE;
                    w_wdata  = w_sel.size;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
                w_ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_bump      <= n_bump;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_hdr <= n_hdr;
        r_res <= n_res;
        r_out <= n_out;
    end

endmodule

>>> rtl/core/ffba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != STAT_OK |-> o_out.address == '0)
        else $error("failed request returned an address");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in flight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

>>> bench/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core
// Self-checking bench for the first-fit block allocator. A directed table
// covers the field extremes, null requests, out-of-memory cases, splits,
// exact fits and unaligned frees, some with typed results. A random part
// then mixes allocates and frees of live blocks, double frees and noise,
// and floods the free table until it reports full. The rest are checked
// against an in-bench model of free table, bump pointer and header sizes.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam int N_RANDOM = 1350;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    first_fit_block_allocator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // allocator model state
    logic [OFF_W-1:0]  tbl_off  [MAX_FREE_ENTRIES];
    logic [SIZE_W-1:0] tbl_size [MAX_FREE_ENTRIES];
    int unsigned       tbl_count;
    int unsigned       bump_ptr;
    logic [SIZE_W-1:0] hdr_sizes [HDR_DEPTH];

    t_out_item   pending_results[$];
    logic [15:0] live_blocks[$];
    logic [15:0] freed_blocks[$];
    bit          failed;
    int          results_taken;
    int          rx_hold;
    bit          rx_calm;

    function automatic t_out_item run_request(t_in_item it);
        t_out_item   r;
        int unsigned sz;
        int unsigned bsz;
        int unsigned off;
        logic [15:0] hdr;
        r.status  = STAT_OK;
        r.address = '0;
        if (it.req_type == REQ_FREE) begin
            if (it.free_address == 0) begin
                r.status = STAT_NULL;
                return r;
            end
            if (tbl_count >= MAX_FREE_ENTRIES) begin
                r.status = STAT_FULL;
                return r;
            end
            hdr = it.free_address - 16'(HDR_BYTES);
            for (int i = tbl_count; i > 0; i--) begin
                tbl_off[i]  = tbl_off[i-1];
                tbl_size[i] = tbl_size[i-1];
            end
            tbl_off[0]  = hdr;
            tbl_size[0] = hdr_sizes[hdr >> 3];
            tbl_count++;
            return r;
        end
        if (it.alloc_size == 0) begin
            r.status = STAT_NULL;
            return r;
        end
        sz = (int'(it.alloc_size) + 7) & ~7;
        for (int i = 0; i < tbl_count; i++) begin
            bsz = tbl_size[i];
            off = tbl_off[i];
            if (bsz >= sz) begin
                if (bsz > sz + HDR_BYTES) begin
                    tbl_off[i]  = 16'(off + HDR_BYTES + sz);
                    tbl_size[i] = 17'(bsz - sz - HDR_BYTES);
                    hdr_sizes[off >> 3] = 17'(sz);
                end else begin
                    for (int k = i; k + 1 < tbl_count; k++) begin
                        tbl_off[k]  = tbl_off[k+1];
                        tbl_size[k] = tbl_size[k+1];
                    end
                    tbl_count--;
                    hdr_sizes[off >> 3] = 17'(bsz);
                end
                r.address = 16'(off + HDR_BYTES);
                return r;
            end
        end
        if (bump_ptr + sz + HDR_BYTES > ARENA_BYTES) begin
            r.status = STAT_OOM;
            return r;
        end
        off = bump_ptr;
        hdr_sizes[off >> 3] = 17'(sz);
        bump_ptr  = off + sz + HDR_BYTES;
        r.address = 16'(off + HDR_BYTES);
        return r;
    endfunction

    // offer one request; typed expectation is used when has_exp is set
    task automatic offer(t_in_item it, bit has_exp, t_out_item exp_r);
        int        gap;
        t_out_item r;
        gap = $urandom_range(0, 3);
        if ((results_taken / 150) % 4 == 1) gap = 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = run_request(it);
        pending_results.push_back(has_exp ? exp_r : r);
        if (it.req_type == REQ_ALLOC && r.status == STAT_OK)
            live_blocks.push_back(r.address);
        if (it.req_type == REQ_FREE && r.status == STAT_OK) begin
            freed_blocks.push_back(it.free_address & 16'hFFF8);
            if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
        end
    endtask

    function automatic logic [16:0] draw_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return 17'($urandom_range(1, 64));
        if (p < 90) return 17'($urandom_range(65, 1024));
        if (p < 98) return 17'($urandom_range(1025, 8192));
        return 17'($urandom);
    endfunction

    // free a live block, with an odd low byte now and then
    task automatic free_live(int idx);
        t_in_item    it;
        logic [15:0] a;
        int          prev_count;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        it.req_type     = REQ_FREE;
        it.alloc_size   = 17'($urandom);
        it.free_address = ($urandom_range(0, 19) == 0) ? (a | 16'($urandom_range(1, 7))) : a;
        prev_count = tbl_count;
        offer(it, 1'b0, '0);
        if (tbl_count == prev_count) live_blocks.push_back(a);  // table full: still live
    endtask

    task automatic random_request();
        t_in_item it;
        int       p;
        p = $urandom_range(0, 99);
        it.alloc_size   = 17'($urandom);
        it.free_address = 16'($urandom);
        if (p < 4) begin
            it.req_type = $urandom_range(0, 1) ? REQ_FREE : REQ_ALLOC;
            it.alloc_size   = '0;
            it.free_address = '0;
            offer(it, 1'b0, '0);
        end else if (p < 7 && freed_blocks.size() > 0) begin
            // double free of a block already returned
            it.req_type     = REQ_FREE;
            it.free_address = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            offer(it, 1'b0, '0);
        end else if (live_blocks.size() > 0 &&
                     (p < 50 || bump_ptr > 56000 || live_blocks.size() > 80)) begin
            free_live($urandom_range(0, live_blocks.size() - 1));
        end else begin
            it.req_type   = REQ_ALLOC;
            it.alloc_size = draw_size();
            offer(it, 1'b0, '0);
        end
    endtask

    typedef struct {
        t_req        req;
        logic [16:0] size;
        logic [15:0] addr;
        bit          has_exp;
        t_status     st;
        logic [15:0] res_addr;
    } t_step;

    t_step steps[] = '{
        '{REQ_ALLOC, 17'd0,      16'hFFFF,  1, STAT_NULL, 16'd0},
        '{REQ_FREE,  17'h1FFFF,  16'd0,     1, STAT_NULL, 16'd0},
        '{REQ_ALLOC, 17'd1,      16'd0,     1, STAT_OK,   16'd16},
        '{REQ_ALLOC, 17'd8,      16'd0,     1, STAT_OK,   16'd40},
        '{REQ_ALLOC, 17'd65536,  16'd0,     1, STAT_OOM,  16'd0},
        '{REQ_ALLOC, 17'h1FFFF,  16'd0,     1, STAT_OOM,  16'd0},
        '{REQ_ALLOC, 17'd40000,  16'd0,     1, STAT_OK,   16'd64},
        '{REQ_ALLOC, 17'd24,     16'd0,     1, STAT_OK,   16'd40080},
        '{REQ_FREE,  17'd0,      16'd40,    1, STAT_OK,   16'd0},
        '{REQ_FREE,  17'd0,      16'd16,    1, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd8,      16'd0,     0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd8,      16'd0,     0, STAT_OK,   16'd0},
        '{REQ_FREE,  17'd0,      16'd64,    0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd100,    16'd0,     0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd25000,  16'd0,     0, STAT_OK,   16'd0},
        '{REQ_FREE,  17'd0,      16'd40080, 0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd24,     16'd0,     0, STAT_OK,   16'd0},
        '{REQ_FREE,  17'd0,      16'd17,    0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd7,      16'd0,     0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd14000,  16'd0,     0, STAT_OK,   16'd0},
        '{REQ_ALLOC, 17'd30000,  16'd0,     0, STAT_OK,   16'd0}
    };

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_taken++;
            rx_hold = (results_taken == 300) ? 400 : (rx_calm ? 0 : $urandom_range(0, 3));
            if ((results_taken / 200) % 3 == 2) rx_hold = 0;
            if (pending_results.size() == 0) begin
                $error("unexpected result status=%0d address=%0d", o_out.status, o_out.address);
                failed = 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (o_out.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_out.status);
                    failed = 1'b1;
                end
                if (o_out.address !== e.address) begin
                    $error("address: expected %0d, got %0d", e.address, o_out.address);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver stall: hold for the drawn number of cycles after each transfer
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item er;
        failed        = 1'b0;
        results_taken = 0;
        rx_hold       = 0;
        rx_calm       = 1'b0;
        tbl_count     = 0;
        bump_ptr      = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            it.req_type     = steps[i].req;
            it.alloc_size   = steps[i].size;
            it.free_address = steps[i].addr;
            er.status       = steps[i].st;
            er.address      = steps[i].res_addr;
            offer(it, steps[i].has_exp, er);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 500 == 250) begin
                // flood: many small blocks, then free everything to fill the table
                for (int k = 0; k < 40; k++) begin
                    it.req_type     = REQ_ALLOC;
                    it.alloc_size   = 17'($urandom_range(1, 16));
                    it.free_address = 16'($urandom);
                    offer(it, 1'b0, '0);
                end
                for (int k = live_blocks.size(); k > 0; k--) free_live(0);
            end
            rx_calm = (n % 400) > 340;
            random_request();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("tb_first_fit_block_allocator_core OK");
        end else begin
            $display("tb_first_fit_block_allocator_core NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_first_fit_block_allocator_core NOT OK");
        $finish;
    end

endmodule
